// ----- rtl/tdli_pkg.sv -----
// ---------------------------------------------------------------------------
// tdli_pkg
// Shared types and constants for the text data line indexer: character
// codes, field widths, counter width defaults, line phase and result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdli_pkg;

  // character codes
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;

  // widths of the result fields
  localparam int OFFSET_W = 32;
  localparam int INDEX_W  = 24;
  localparam int COUNT_W  = 16;

  // default counter widths
  localparam int POSITION_BITS_DEF = 32;
  localparam int LINE_BITS_DEF     = 24;
  localparam int COLUMN_BITS_DEF   = 16;

  // where the scanner stands within the current line
  typedef enum logic [1:0] {
    PHASE_LEAD  = 2'd0,
    PHASE_FIRST = 2'd1,
    PHASE_SKIP  = 2'd2
  } tdli_phase_t;

  // one result word
  typedef struct packed {
    logic                offset_valid;
    logic [OFFSET_W-1:0] line_offset;
    logic [INDEX_W-1:0]  line_index;
    logic                width_valid;
    logic [COUNT_W-1:0]  column_count;
    logic                buffer_done;
    logic [INDEX_W-1:0]  total_lines;
    logic                no_data_error;
  } tdli_result_t;

endpackage

// ----- rtl/text_data_line_indexer_unit.sv -----
// ---------------------------------------------------------------------------
// text_data_line_indexer_unit
// Streaming indexer of data lines in a text buffer, one byte per word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Takes one byte per cycle while the output is taken and gives one result word per
// byte. A byte is registered in the input stage on acceptance, evaluated there
// against the line scan state, and lands in the output register once that
// register is empty or taken. The sustained rate is one byte per cycle, set by
// the update of the scan state (phase, token and line counters) once per byte.
// The input stage can take one more byte while a result waits at the output,
// and stalls when the input stage and the output register are full and the output is not taken.
// The word carrying last_byte reports the totals and clears all scan state.
module text_data_line_indexer_unit #(
  parameter int POSITION_BITS = tdli_pkg::POSITION_BITS_DEF,
  parameter int LINE_BITS     = tdli_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS   = tdli_pkg::COLUMN_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    text_byte,
  input  logic                          last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          offset_valid,
  output logic [tdli_pkg::OFFSET_W-1:0] line_offset,
  output logic [tdli_pkg::INDEX_W-1:0]  line_index,
  output logic                          width_valid,
  output logic [tdli_pkg::COUNT_W-1:0]  column_count,
  output logic                          buffer_done,
  output logic [tdli_pkg::INDEX_W-1:0]  total_lines,
  output logic                          no_data_error
);
  import tdli_pkg::*;

  // input stage
  logic         stage_valid;
  logic [7:0]   stage_byte;
  logic         stage_last;
  logic         advance;
  tdli_result_t step_result;
  tdli_result_t out_word;

  // output register frees when empty or taken
  always_comb begin
    advance  = stage_valid && (!out_valid || out_ready);
    in_ready = !stage_valid || advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= text_byte;
      stage_last <= last_byte;
    end
  end

  // scan state and per-byte result
  tdli_tracker #(
    .POSITION_BITS (POSITION_BITS),
    .LINE_BITS     (LINE_BITS),
    .COLUMN_BITS   (COLUMN_BITS)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .text_byte (stage_byte),
    .last_byte (stage_last),
    .result    (step_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= step_result;
    end
  end

  assign offset_valid  = out_word.offset_valid;
  assign line_offset   = out_word.line_offset;
  assign line_index    = out_word.line_index;
  assign width_valid   = out_word.width_valid;
  assign column_count  = out_word.column_count;
  assign buffer_done   = out_word.buffer_done;
  assign total_lines   = out_word.total_lines;
  assign no_data_error = out_word.no_data_error;

  // a byte held in the input stage is not dropped
  assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |=> (stage_valid && $stable(stage_byte)))
    else $error("input stage lost a held byte");

  // a reported width always counts the token that started the line
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && width_valid) |-> (column_count != '0))
    else $error("width reported with zero tokens");

  // the empty buffer flag only comes with the final word and zero lines
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_data_error) |-> (buffer_done && total_lines == '0 && !offset_valid))
    else $error("no data flag inconsistent with totals");

  // a data line starting on the final byte is counted in the total
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && buffer_done && offset_valid) |-> (total_lines != '0))
    else $error("data line on final byte missing from total");

endmodule

// ----- rtl/tdli_tracker.sv -----
// ---------------------------------------------------------------------------
// tdli_tracker
// Per-buffer scan state and the result logic for one byte. The result is
// combinational from the presented byte; state commits when advance is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdli_tracker #(
  parameter int POSITION_BITS = tdli_pkg::POSITION_BITS_DEF,
  parameter int LINE_BITS     = tdli_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS   = tdli_pkg::COLUMN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [7:0]            text_byte,
  input  logic                  last_byte,
  output tdli_pkg::tdli_result_t result
);
  import tdli_pkg::*;

  // state registers
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [LINE_BITS-1:0]     data_line_count, data_line_count_next;
  tdli_phase_t              line_phase, line_phase_next;
  logic                     first_line_pending, first_line_pending_next;
  logic                     inside_token, inside_token_next;
  logic                     counting_stopped, counting_stopped_next;
  logic [COLUMN_BITS-1:0]   token_tally, token_tally_next;

  // byte classes
  logic is_eol, is_blank, is_hash, starts_data;

  always_comb begin
    is_eol      = (text_byte == CH_LF) || (text_byte == CH_CR);
    is_blank    = text_byte inside {CH_SP, CH_TAB, CH_VT, CH_FF};
    is_hash     = (text_byte == CH_HASH);
    starts_data = !is_eol && (line_phase == PHASE_LEAD) && !is_hash && !is_blank;
  end

  // next state
  always_comb begin
    byte_position_next      = (byte_position == '1) ? byte_position
                                                    : byte_position + POSITION_BITS'(1);
    data_line_count_next    = data_line_count;
    line_phase_next         = line_phase;
    first_line_pending_next = first_line_pending;
    inside_token_next       = inside_token;
    counting_stopped_next   = counting_stopped;
    token_tally_next        = token_tally;

    if (is_eol) begin
      line_phase_next   = PHASE_LEAD;
      inside_token_next = 1'b0;
    end else if (line_phase == PHASE_LEAD) begin
      if (is_hash) begin
        line_phase_next = PHASE_SKIP;
      end else if (!is_blank) begin
        data_line_count_next = (data_line_count == '1) ? data_line_count
                                                       : data_line_count + LINE_BITS'(1);
        if (first_line_pending) begin
          first_line_pending_next = 1'b0;
          line_phase_next         = PHASE_FIRST;
          token_tally_next        = COLUMN_BITS'(1);
          inside_token_next       = 1'b1;
        end else begin
          line_phase_next = PHASE_SKIP;
        end
      end
    end else if (line_phase == PHASE_FIRST && !counting_stopped) begin
      if (is_hash) begin
        counting_stopped_next = 1'b1;
      end else if (is_blank) begin
        inside_token_next = 1'b0;
      end else if (!inside_token) begin
        token_tally_next  = (token_tally == '1) ? token_tally
                                                : token_tally + COLUMN_BITS'(1);
        inside_token_next = 1'b1;
      end
    end
  end

  // result word for the presented byte
  always_comb begin
    result.offset_valid  = starts_data;
    result.line_offset   = starts_data ? OFFSET_W'(byte_position) : '0;
    result.line_index    = starts_data ? INDEX_W'(data_line_count) : '0;
    result.width_valid   = (is_eol && line_phase == PHASE_FIRST) ||
                           (last_byte && line_phase_next == PHASE_FIRST);
    result.column_count  = result.width_valid ? COUNT_W'(token_tally_next) : '0;
    result.buffer_done   = last_byte;
    result.total_lines   = last_byte ? INDEX_W'(data_line_count_next) : '0;
    result.no_data_error = last_byte && (data_line_count_next == '0);
  end

  // commit state; the final byte returns everything to reset values
  always_ff @(posedge clk) begin
    if (rst || (advance && last_byte)) begin
      byte_position      <= '0;
      data_line_count    <= '0;
      line_phase         <= PHASE_LEAD;
      first_line_pending <= 1'b1;
      inside_token       <= 1'b0;
      counting_stopped   <= 1'b0;
      token_tally        <= '0;
    end else if (advance) begin
      byte_position      <= byte_position_next;
      data_line_count    <= data_line_count_next;
      line_phase         <= line_phase_next;
      first_line_pending <= first_line_pending_next;
      inside_token       <= inside_token_next;
      counting_stopped   <= counting_stopped_next;
      token_tally        <= token_tally_next;
    end
  end

  // the first data line phase only exists once a data line has been seen
  assert property (@(posedge clk) disable iff (rst)
    (line_phase == PHASE_FIRST) |-> (!first_line_pending && token_tally != '0))
    else $error("first line phase without a started data line");

endmodule

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for text_data_line_indexer_unit. Bytes of text
// buffers go in through a valid/ready channel with random gaps. A local
// line scanner predicts the result word of every byte, and each word taken
// from the block is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tdli_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;
  localparam int LONG_PAIRS = 40;
  localparam int MAX_PRINTS = 20;

  localparam logic [POSITION_BITS_DEF-1:0] POS_MAX = '1;
  localparam logic [LINE_BITS_DEF-1:0] LINE_MAX = '1;
  localparam logic [COLUMN_BITS_DEF-1:0] COL_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] text_byte = 8'h00;
  logic last_byte = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic offset_valid;
  logic [OFFSET_W-1:0] line_offset;
  logic [INDEX_W-1:0] line_index;
  logic width_valid;
  logic [COUNT_W-1:0] column_count;
  logic buffer_done;
  logic [INDEX_W-1:0] total_lines;
  logic no_data_error;

  // scan state of the predictor
  logic [POSITION_BITS_DEF-1:0] pos_next;
  logic [LINE_BITS_DEF-1:0] lines_found;
  tdli_phase_t scan_phase;
  logic first_pending;
  logic in_token;
  logic hash_seen;
  logic [COLUMN_BITS_DEF-1:0] first_line_tokens;

  tdli_result_t expected_words[$];

  // run bookkeeping
  int mismatches = 0;
  int bytes_sent = 0;
  int words_checked = 0;
  int buffers_closed = 0;
  int data_lines_seen = 0;
  int random_items = 0;
  int idle_cycles = 0;
  bit src_idle = 1'b1;
  bit snk_idle = 1'b1;
  int hold_request = 0;
  bit hold_active = 1'b0;

  text_data_line_indexer_unit DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .text_byte(text_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .offset_valid(offset_valid),
    .line_offset(line_offset),
    .line_index(line_index),
    .width_valid(width_valid),
    .column_count(column_count),
    .buffer_done(buffer_done),
    .total_lines(total_lines),
    .no_data_error(no_data_error)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_SP || b == CH_TAB || b == CH_VT || b == CH_FF;
  endfunction

  function automatic void clear_scan_state();
    pos_next = '0;
    lines_found = '0;
    scan_phase = PHASE_LEAD;
    first_pending = 1'b1;
    in_token = 1'b0;
    hash_seen = 1'b0;
    first_line_tokens = '0;
  endfunction

  // line scanner: one byte in, the result word it should produce out
  function automatic tdli_result_t predict_byte(input logic [7:0] b, input logic fin);
    tdli_result_t r;
    r = '0;
    if (b == CH_LF || b == CH_CR) begin
      if (scan_phase == PHASE_FIRST) begin
        r.width_valid = 1'b1;
        r.column_count = first_line_tokens;
      end
      scan_phase = PHASE_LEAD;
      in_token = 1'b0;
    end else if (scan_phase == PHASE_LEAD) begin
      if (b == CH_HASH) begin
        scan_phase = PHASE_SKIP;
      end else if (!is_blank(b)) begin
        r.offset_valid = 1'b1;
        r.line_offset = pos_next;
        r.line_index = lines_found;
        if (lines_found != LINE_MAX) lines_found = lines_found + 1'b1;
        if (first_pending) begin
          first_pending = 1'b0;
          scan_phase = PHASE_FIRST;
          first_line_tokens = COLUMN_BITS_DEF'(1);
          in_token = 1'b1;
        end else begin
          scan_phase = PHASE_SKIP;
        end
      end
    end else if (scan_phase == PHASE_FIRST && !hash_seen) begin
      // token counting on the first data line, up to a comment mark
      if (b == CH_HASH) begin
        hash_seen = 1'b1;
      end else if (is_blank(b)) begin
        in_token = 1'b0;
      end else if (!in_token) begin
        if (first_line_tokens != COL_MAX) first_line_tokens = first_line_tokens + 1'b1;
        in_token = 1'b1;
      end
    end
    if (fin) begin
      if (scan_phase == PHASE_FIRST) begin
        r.width_valid = 1'b1;
        r.column_count = first_line_tokens;
      end
      r.buffer_done = 1'b1;
      r.total_lines = lines_found;
      r.no_data_error = (lines_found == 0);
    end
    if (pos_next != POS_MAX) pos_next = pos_next + 1'b1;
    if (fin) clear_scan_state();
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("tb: mismatch on %s at word %0d: got 0x%0h, want 0x%0h",
               field, words_checked, got, want);
  endtask

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  // send one word, after a random gap, and predict its result on acceptance
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = src_idle ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    text_byte = b;
    last_byte = fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_words.push_back(predict_byte(b, fin));
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit close_buffer);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], close_buffer && i == s.len() - 1);
  endtask

  function automatic logic [7:0] token_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_LF || c == CH_CR || c == CH_HASH || is_blank(c))
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  // receiver: random stall per word, long hold-off on request
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_active = 1'b1;
        out_ready = 1'b0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
        hold_active = 1'b0;
      end
      stall = snk_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid && hold_request == 0) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    tdli_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 64'd1, 64'd0);
      end else begin
        want = expected_words.pop_front();
        check_field("offset_valid", offset_valid, want.offset_valid);
        check_field("line_offset", line_offset, want.line_offset);
        check_field("line_index", line_index, want.line_index);
        check_field("width_valid", width_valid, want.width_valid);
        check_field("column_count", column_count, want.column_count);
        check_field("buffer_done", buffer_done, want.buffer_done);
        check_field("total_lines", total_lines, want.total_lines);
        check_field("no_data_error", no_data_error, want.no_data_error);
        if (want.buffer_done) buffers_closed++;
        if (want.offset_valid) data_lines_seen++;
      end
      words_checked++;
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // first data line with mixed blanks, a comment mark and a CR LF pair
  task automatic test_first_line();
    send_text("\011a b\013c#d e\015\012", 1'b0);
  endtask

  // comment line, later data lines, data line starting on the final byte
  task automatic test_later_lines();
    send_text("#q\012\014z\012y", 1'b1);
  endtask

  // buffers of one or a few bytes: blank only, comment only, one-byte data, blank-led data
  task automatic test_buffer_edges();
    send_text("\014", 1'b1);
    send_text("#", 1'b1);
    send_text("k", 1'b1);
    send_text("\013p q", 1'b1);
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    // drop valid so the last word is not offered again while waiting
    @(negedge clk);
    in_valid = 1'b0;
    src_idle = 1'b0;
    hold_request = HOLD_CYCLES;
    wait (hold_active);
    send_text("r0 r1\012 s2\012#t\012u", 1'b1);
    send_text("ab cd ef gh\012ij", 1'b1);
    src_idle = 1'b1;
  endtask

  // first data line with many tokens, sent back to back
  task automatic test_long_first_line();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    send_byte("a", 1'b0);
    repeat (LONG_PAIRS) begin
      send_byte(CH_SP, 1'b0);
      send_byte("b", 1'b0);
    end
    send_byte(CH_LF, 1'b1);
    src_idle = 1'b1;
    snk_idle = 1'b1;
  endtask

  // well-formed buffers with random content, mixed with raw noise
  task automatic test_random_buffers();
    logic [7:0] text_q[$];
    int n_lines;
    int kind;
    while (random_items < RANDOM_ITEMS) begin
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      text_q.delete();
      if ($urandom_range(0, 4) == 0) begin
        // noise, with the final mark dropped in at random
        repeat ($urandom_range(1, 20)) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
          random_items++;
        end
      end else begin
        n_lines = $urandom_range(1, 8);
        for (int l = 0; l < n_lines; l++) begin
          repeat ($urandom_range(0, 3)) text_q.push_back(blank_char());
          kind = $urandom_range(0, 9);
          if (kind >= 2 && kind < 4) begin
            // comment line
            text_q.push_back(CH_HASH);
            repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom_range(0, 255)));
            while (text_q[$] == CH_LF || text_q[$] == CH_CR) void'(text_q.pop_back());
          end else if (kind >= 4) begin
            // data line: tokens, optional trailing comment
            repeat ($urandom_range(1, 6)) begin
              repeat ($urandom_range(1, 4)) text_q.push_back(token_char());
              repeat ($urandom_range(1, 2)) text_q.push_back(blank_char());
            end
            if ($urandom_range(0, 2) == 0) begin
              text_q.push_back(CH_HASH);
              repeat ($urandom_range(0, 4)) text_q.push_back(token_char());
              text_q.push_back(blank_char());
              text_q.push_back(token_char());
            end
            if ($urandom_range(0, 1) == 0) void'(text_q.pop_back());
          end
          if (l < n_lines - 1 || $urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 2))
              0: text_q.push_back(CH_LF);
              1: text_q.push_back(CH_CR);
              default: begin
                text_q.push_back(CH_CR);
                text_q.push_back(CH_LF);
              end
            endcase
          end
        end
        if (text_q.size() == 0) text_q.push_back(CH_LF);
        foreach (text_q[i]) begin
          send_byte(text_q[i], i == text_q.size() - 1);
          random_items++;
        end
      end
    end
    src_idle = 1'b1;
    snk_idle = 1'b1;
  endtask

  // test sequence
  initial begin
    clear_scan_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_first_line();
    test_later_lines();
    test_buffer_edges();
    test_backpressure();
    test_long_first_line();
    test_random_buffers();

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("tb: %0d bytes sent, %0d words checked, %0d buffers closed, %0d data lines",
             bytes_sent, words_checked, buffers_closed, data_lines_seen);
    $display("tb: directed lines, buffer edges, long hold-off, long first line, %0d random",
             random_items);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
